FILE: design/mcoc_pkg.sv
// ----------------------------------------------------------------------------
// mcoc_pkg
// shared types and constants for the matrix chain order cost unit
// ----------------------------------------------------------------------------
package mcoc_pkg;

  localparam int MAX_MATRICES_DEF = 64;
  localparam int DIM_WIDTH_DEF    = 16;
  localparam int COST_W           = 64;
  localparam int IN_DIM_W         = 16;
  localparam int USED_W           = 7;

  // cost cap: 2^63
  localparam logic [COST_W-1:0] COST_CAP = {1'b1, {(COST_W-1){1'b0}}};

  typedef struct packed {
    logic [IN_DIM_W-1:0] row_count;
    logic [IN_DIM_W-1:0] col_count;
    logic                chain_end;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-2:0] min_cost;
    logic [USED_W-1:0] matrices_used;
    logic              overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_RD,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_WR,
    ST_DONE
  } mcoc_state_t;

  // saturating add at the cap
  function automatic logic [COST_W-1:0] cap_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    cap_add = (s > {1'b0, COST_CAP}) ? COST_CAP : s[COST_W-1:0];
  endfunction

endpackage

FILE: design/matrix_chain_order_cost_unit.sv
// ----------------------------------------------------------------------------
// matrix_chain_order_cost_unit
// least scalar multiplication count for a chain of matrices
// ----------------------------------------------------------------------------
// usage: pulse start with in_item while busy is low, one matrix per item.
// an item that is not the chain end is taken while start is high and busy stays low,
// so matrices load one per cycle. row_count is used for the first matrix
// only; matrices past MAX_MATRICES are dropped and flag overflow.
// on the chain end item busy rises and the cost table is filled over chain
// lengths 2..n and split points. each split point steps through the table
// reads, two registered multiplies, add and compare. each table entry also
// turns the cell ring a lap so both end dimensions pass the head, plus its
// write; the run time is set by the single multiplier/adder path, the
// single-ported cost table and the ring lap.
// the dimension cells form a chain that rotates by one per step so the split
// dimension sits at the head cell.
// the result appears on out_item for one cycle with out_valid; the
// receiver cannot stall. reset clears the chain count and the overflow flag;
// the cost table needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module matrix_chain_order_cost_unit import mcoc_pkg::*; #(
  parameter int MAX_MATRICES = MAX_MATRICES_DEF,
  parameter int DIM_WIDTH    = DIM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int NW  = $clog2(MAX_MATRICES + 1);
  localparam int IW  = $clog2(MAX_MATRICES);
  localparam int ND  = MAX_MATRICES + 1;
  localparam int DW2 = 2 * DIM_WIDTH;
  localparam int TW  = 2 * IW;
  localparam int PW  = (3 * DIM_WIDTH > COST_W + 1) ? 3 * DIM_WIDTH : COST_W + 1;

  mcoc_state_t state_r, state_nxt;

  logic [NW-1:0]  len_r, len_nxt;     // kept matrices
  logic           many_r, many_nxt;
  logic [IW-1:0]  i_r, i_nxt;
  logic [IW-1:0]  j_r, j_nxt;
  logic [IW-1:0]  k_r, k_nxt;
  logic [NW-1:0]  cl_r, cl_nxt;       // current chain length
  logic [COST_W-1:0] best_r, best_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;
  logic           dj_seen_r, dj_seen_nxt;  // far dimension captured this lap

  // dimension chain of cells
  logic [DIM_WIDTH-1:0] dims [ND];
  logic                 cell_wr [ND];
  logic                 shift_en;
  logic [DIM_WIDTH-1:0] wr_dim;
  logic [DIM_WIDTH-1:0] row_dim;

  // captured dimensions of the current entry
  logic [DIM_WIDTH-1:0] di_r, di_nxt, dj_r, dj_nxt;

  assign row_dim = DIM_WIDTH'(in_item.row_count);

  genvar g;
  generate
    for (g = 0; g < ND; g++) begin : g_cell
      mcoc_cell #(.DIM_WIDTH(DIM_WIDTH)) u_cell (
        .clk     (clk),
        .wr_en   (cell_wr[g]),
        .wr_dim  ((g == 0) ? row_dim : wr_dim),
        .shift_en(shift_en),
        .shift_in(dims[(g + 1) % ND]),
        .dim     (dims[g])
      );
    end
  endgenerate

  // cost table memory, single port
  logic [COST_W-1:0] cost_mem [MAX_MATRICES * MAX_MATRICES];
  logic [TW-1:0]     mem_addr;
  logic              mem_we;
  logic [COST_W-1:0] mem_wdata;
  logic [COST_W-1:0] mem_rdata_r;
  logic [COST_W-1:0] left_r, left_nxt;
  logic              rd_phase_r, rd_phase_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cost_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= cost_mem[mem_addr];
  end

  // multiply pipeline
  logic [DW2-1:0]    p1_r;
  logic [PW-1:0]     p2_r;
  logic [DIM_WIDTH-1:0] dk;
  logic [COST_W-1:0] term, q;

  assign dk = dims[0];  // rotated so head holds dimension k+1
  always_ff @(posedge clk) begin
    p1_r <= DW2'(di_r) * DW2'(dk);
    p2_r <= PW'(p1_r) * PW'(dj_r);
  end
  assign term = (p2_r > PW'(COST_CAP)) ? COST_CAP : p2_r[COST_W-1:0];
  assign q    = cap_add(cap_add(left_r, mem_rdata_r), term);

  function automatic logic [TW-1:0] addr(input logic [IW-1:0] a,
                                         input logic [IW-1:0] b);
    addr = TW'(a) * TW'(MAX_MATRICES) + TW'(b);
  endfunction

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      len_r       <= '0;
      many_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      many_r      <= many_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    cl_r       <= cl_nxt;
    best_r     <= best_nxt;
    out_r      <= out_nxt;
    di_r       <= di_nxt;
    dj_r       <= dj_nxt;
    left_r     <= left_nxt;
    rd_phase_r <= rd_phase_nxt;
    dj_seen_r  <= dj_seen_nxt;
  end

  logic [NW:0] rot_cnt_r, rot_cnt_nxt;  // rotation position of chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cnt_r <= '0;
    end else begin
      rot_cnt_r <= rot_cnt_nxt;
    end
  end

  logic [NW-1:0] k1;
  assign k1 = NW'(k_r) + NW'(1);

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    many_nxt      = many_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cl_nxt        = cl_r;
    best_nxt      = best_r;
    di_nxt        = di_r;
    dj_nxt        = dj_r;
    left_nxt      = left_r;
    rd_phase_nxt  = rd_phase_r;
    dj_seen_nxt   = dj_seen_r;
    rot_cnt_nxt   = rot_cnt_r;
    shift_en      = 1'b0;
    wr_dim        = DIM_WIDTH'(in_item.col_count);
    mem_we        = 1'b0;
    mem_wdata     = '0;
    mem_addr      = addr(i_r, j_r);
    busy          = 1'b1;
    for (int c = 0; c < ND; c++) begin
      cell_wr[c] = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (len_r == '0) begin
            cell_wr[0] = 1'b1;
          end
          if (len_r < NW'(MAX_MATRICES)) begin
            len_nxt = len_r + NW'(1);
          end else begin
            many_nxt = 1'b1;
          end
          if (in_item.chain_end) begin
            state_nxt   = ST_ROW;
            i_nxt       = '0;
            cl_nxt      = NW'(1);
            dj_seen_nxt = 1'b0;
          end
        end
      end
      // diagonal entries, then per chain length entry setup
      ST_ROW: begin
        if (cl_r == NW'(1)) begin
          mem_we    = 1'b1;
          mem_addr  = addr(i_r, i_r);
          mem_wdata = '0;
          if (NW'(i_r) + NW'(1) >= len_r) begin
            i_nxt  = '0;
            cl_nxt = NW'(2);
            if (len_r == NW'(1)) begin
              state_nxt = ST_DONE;
            end
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else if (NW'(i_r) + cl_r > len_r) begin
          if (cl_r == len_r) begin
            state_nxt = ST_DONE;
          end else begin
            cl_nxt = cl_r + NW'(1);
            i_nxt  = '0;
          end
        end else if (rot_cnt_r != (NW+1)'(i_r) + (NW+1)'(1) || !dj_seen_r) begin
          // turn the ring past dimension j+1, then on until the head holds i+1
          shift_en    = 1'b1;
          rot_cnt_nxt = (rot_cnt_r == (NW+1)'(ND - 1)) ? '0 : rot_cnt_r + 1'b1;
          if (rot_cnt_r == (NW+1)'(i_r)) begin
            di_nxt = dims[0];
          end
          if (rot_cnt_r == (NW+1)'(NW'(i_r) + cl_r)) begin
            dj_nxt      = dims[0];
            dj_seen_nxt = 1'b1;
          end
        end else begin
          j_nxt        = IW'(NW'(i_r) + cl_r - NW'(1));
          k_nxt        = i_r;
          best_nxt     = COST_CAP;
          rd_phase_nxt = 1'b0;
          dj_seen_nxt  = 1'b0;
          state_nxt    = ST_RD;
        end
      end
      // read left then right subcosts
      ST_RD: begin
        if (!rd_phase_r) begin
          mem_addr     = addr(i_r, k_r);
          rd_phase_nxt = 1'b1;
        end else begin
          mem_addr  = addr(IW'(k1), j_r);
          left_nxt  = mem_rdata_r;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        mem_addr  = addr(IW'(k1), j_r);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        mem_addr  = addr(IW'(k1), j_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        mem_addr = addr(IW'(k1), j_r);
        if (q < best_r) begin
          best_nxt = q;
        end
        shift_en    = 1'b1;
        rot_cnt_nxt = (rot_cnt_r == (NW+1)'(ND - 1)) ? '0 : rot_cnt_r + 1'b1;
        if (k1 == NW'(j_r)) begin
          state_nxt = ST_WR;
        end else begin
          k_nxt        = IW'(k1);
          rd_phase_nxt = 1'b0;
          state_nxt    = ST_RD;
        end
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_wdata = best_r;
        i_nxt     = i_r + IW'(1);
        state_nxt = ST_ROW;
      end
      ST_DONE: begin
        mem_addr = addr('0, IW'(len_r - NW'(1)));
        if (rd_phase_r) begin
          out_valid_nxt         = 1'b1;
          out_nxt.matrices_used = USED_W'(len_r);
          out_nxt.overflow      = many_r | mem_rdata_r[COST_W-1];
          out_nxt.min_cost      = mem_rdata_r[COST_W-1] ? '1 : mem_rdata_r[COST_W-2:0];
          len_nxt               = '0;
          many_nxt              = 1'b0;
          rot_cnt_nxt           = '0;
          state_nxt             = ST_LOAD;
        end else begin
          rd_phase_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    if (state_r == ST_LOAD && start && len_r < NW'(MAX_MATRICES)) begin
      cell_wr[int'(len_r) + 1] = 1'b1;
    end
    if (state_r == ST_ROW && cl_r == len_r && NW'(i_r) + cl_r > len_r) begin
      rd_phase_nxt = 1'b0;
    end
    if (state_r == ST_ROW && cl_r == NW'(1) && len_r == NW'(1)) begin
      rd_phase_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: design/mcoc_cell.sv
// ----------------------------------------------------------------------------
// mcoc_cell
// one cell of the dimension chain: holds one dimension, shifts to neighbour
// ----------------------------------------------------------------------------
module mcoc_cell import mcoc_pkg::*; #(
  parameter int DIM_WIDTH = DIM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [DIM_WIDTH-1:0] wr_dim,
  input  logic                 shift_en,
  input  logic [DIM_WIDTH-1:0] shift_in,
  output logic [DIM_WIDTH-1:0] dim
);

  logic [DIM_WIDTH-1:0] dim_r;

  // own write has priority over the shift from the neighbour
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dim_r <= wr_dim;
    end else if (shift_en) begin
      dim_r <= shift_in;
    end
  end

  assign dim = dim_r;

endmodule

FILE: design/mcoc_checker.sv
// ----------------------------------------------------------------------------
// mcoc_checker
// port level checks for the matrix chain order cost unit
// ----------------------------------------------------------------------------
module mcoc_checker import mcoc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // a result is a single cycle pulse
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");

  // a result rises only after the block has been busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy)) else $error("result while idle");

  // the kept count is never zero
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.matrices_used != '0) else $error("empty chain");

  // saturated cost implies overflow flag
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (&out_item.min_cost) |-> out_item.overflow)
    else $error("saturation without overflow");

endmodule

bind matrix_chain_order_cost_unit mcoc_checker u_mcoc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);
